[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands: clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent
`define MTM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent
`define MTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mtm_pkg.sv]
// ----------------------------------------------------------------------------
// mtm_pkg
// Shared types and constants of the track to MIDI transcoder.
// ----------------------------------------------------------------------------
package mtm_pkg;

  // Default longest delta time, in 7-bit groups
  localparam int MAX_DELTA_BYTES_DEF = 4;
  // Jobs held between front and back
  localparam int QUEUE_DEPTH = 4;

  // Byte codes
  localparam logic [7:0] STATUS_META  = 8'hFF;
  localparam logic [7:0] META_END     = 8'h2F;
  localparam logic [7:0] GROUP_MASK   = 8'h7F;
  localparam logic [7:0] CONT_BIT     = 8'h80;
  localparam logic [3:0] HI_SYSTEM    = 4'hF;
  localparam logic [3:0] HI_PROG_CHG  = 4'hC;
  localparam logic [3:0] HI_CHAN_PRES = 4'hD;

  // Parse phase, one-hot
  typedef enum logic [7:0] {
    PH_DELTA  = 8'b0000_0001,
    PH_STATUS = 8'b0000_0010,
    PH_DATA   = 8'b0000_0100,
    PH_MTYPE  = 8'b0000_1000,
    PH_MLEN   = 8'b0001_0000,
    PH_MBODY  = 8'b0010_0000,
    PH_DONE   = 8'b0100_0000,
    PH_ERROR  = 8'b1000_0000
  } phase_t;

  // Per-job control passed from front to back
  typedef struct packed {
    logic clr;           // track start: clear byte count first
    logic has;           // results carry bytes
    logic track_end;     // flag on last result
    logic format_error;  // flag on last result
  } job_flags_t;

endpackage

[design/music_track_to_midi_transcoder_unit.sv]
// ----------------------------------------------------------------------------
// music_track_to_midi_transcoder_unit
// Converts a game-music track, one source byte per transaction, into the
// bytes of a standard MIDI track with big-endian delta times and running
// status.
// ----------------------------------------------------------------------------
// A source byte is taken every cycle while the job queue (QUEUE_DEPTH jobs)
// has room; each byte is parsed in the cycle it is accepted, and its results
// pass through the job queue and then the output register. Results leave at
// one per cycle while out_ready allows: most bytes give one result, the final
// group of a delta time gives up to MAX_DELTA_BYTES results, so a delta burst
// holds the output while the queue absorbs further input. The sustained input
// rate is one byte per cycle, less when delta bursts or output stalls hold
// the output port back. No clearing pass follows reset.
module music_track_to_midi_transcoder_unit import mtm_pkg::*; #(
  parameter int MAX_DELTA_BYTES = MAX_DELTA_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_track_byte,
  input  logic        in_track_start,
  input  logic        in_last_in_track,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_byte,
  output logic        out_has_byte,
  output logic        out_last_of_run,
  output logic        out_track_end,
  output logic        out_format_error,
  output logic [31:0] out_byte_count
);

  localparam int CNT_W = $clog2(MAX_DELTA_BYTES + 1);
  localparam int JOB_W = MAX_DELTA_BYTES * 8 + CNT_W + $bits(job_flags_t);

  logic                            accept;
  logic [MAX_DELTA_BYTES-1:0][7:0] f_bytes, q_bytes;
  logic [CNT_W-1:0]                f_cnt, q_cnt;
  job_flags_t                      f_flags, q_flags;
  logic [JOB_W-1:0]                f_job, q_job;
  logic                            q_valid;
  logic                            q_pop;

  assign accept = in_valid && in_ready;

  // Front: parse and classify
  mtm_front #(.MAX_DELTA_BYTES(MAX_DELTA_BYTES)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .track_byte    (in_track_byte),
    .track_start   (in_track_start),
    .last_in_track (in_last_in_track),
    .job_bytes     (f_bytes),
    .job_cnt       (f_cnt),
    .job_flags     (f_flags)
  );

  assign f_job = {f_flags, f_cnt, f_bytes};
  assign {q_flags, q_cnt, q_bytes} = q_job;

  // Job queue between front and back
  mtm_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (f_job),
    .not_full  (in_ready),
    .pop       (q_pop),
    .head_data (q_job),
    .not_empty (q_valid)
  );

  // Back: emit results
  mtm_back #(.MAX_DELTA_BYTES(MAX_DELTA_BYTES)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_bytes          (q_bytes),
    .q_cnt            (q_cnt),
    .q_flags          (q_flags),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_byte    (out_data_byte),
    .out_has_byte     (out_has_byte),
    .out_last_of_run  (out_last_of_run),
    .out_track_end    (out_track_end),
    .out_format_error (out_format_error),
    .out_byte_count   (out_byte_count)
  );

endmodule

[design/mtm_queue.sv]
// ----------------------------------------------------------------------------
// mtm_queue
// Small register FIFO carrying decoded jobs from front to back.
// ----------------------------------------------------------------------------
module mtm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             not_empty
);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign not_full  = (fill_r != CNT_W'(DEPTH));
  assign not_empty = (fill_r != '0);
  assign head_data = store_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[design/mtm_front.sv]
// ----------------------------------------------------------------------------
// mtm_front
// Source byte parser: tracks the event phase and turns each byte into a job
// of one to MAX_DELTA_BYTES output results.
// ----------------------------------------------------------------------------
module mtm_front import mtm_pkg::*; #(
  parameter int MAX_DELTA_BYTES = MAX_DELTA_BYTES_DEF,
  localparam int DC_W  = (MAX_DELTA_BYTES > 1) ? $clog2(MAX_DELTA_BYTES) : 1,
  localparam int CNT_W = $clog2(MAX_DELTA_BYTES + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [7:0]                        track_byte,
  input  logic                              track_start,
  input  logic                              last_in_track,
  output logic [MAX_DELTA_BYTES-1:0][7:0]   job_bytes,
  output logic [CNT_W-1:0]                  job_cnt,
  output job_flags_t                        job_flags
);

  phase_t      phase_r, phase_nxt, phase_fin, e_phase;
  logic [DC_W-1:0] dc_r, dc_nxt, e_dc;
  logic [7:0]  prev_r, prev_nxt, e_prev;
  logic [1:0]  data_left_r, data_left_nxt;
  logic [7:0]  meta_left_r, meta_left_nxt;
  logic        meta_end_r, meta_end_nxt;
  logic [6:0]  groups_r [MAX_DELTA_BYTES];
  logic        grp_we;
  logic        emit_one;
  logic        emit_delta;

  // Phase update for one source byte
  always_comb begin
    e_phase       = track_start ? PH_DELTA : phase_r;
    e_dc          = track_start ? '0 : dc_r;
    e_prev        = track_start ? '0 : prev_r;
    phase_nxt     = e_phase;
    dc_nxt        = e_dc;
    prev_nxt      = e_prev;
    data_left_nxt = data_left_r;
    meta_left_nxt = meta_left_r;
    meta_end_nxt  = meta_end_r;
    grp_we        = 1'b0;
    emit_one      = 1'b0;
    emit_delta    = 1'b0;
    case (e_phase)
      PH_DELTA: begin
        if (track_byte[7]) begin
          emit_delta = 1'b1;
          dc_nxt     = '0;
          phase_nxt  = PH_STATUS;
        end else if (int'(e_dc) + 1 >= MAX_DELTA_BYTES) begin
          phase_nxt = PH_ERROR;
        end else begin
          grp_we = 1'b1;
          dc_nxt = e_dc + 1'b1;
        end
      end
      PH_STATUS: begin
        if (track_byte == STATUS_META) begin
          emit_one  = 1'b1;
          phase_nxt = PH_MTYPE;
        end else if (!track_byte[7] || track_byte[7:4] == HI_SYSTEM) begin
          phase_nxt = PH_ERROR;
        end else begin
          data_left_nxt = (track_byte[7:4] inside {HI_PROG_CHG, HI_CHAN_PRES}) ? 2'd1 : 2'd2;
          emit_one      = (track_byte != e_prev);
          prev_nxt      = track_byte;
          phase_nxt     = PH_DATA;
        end
      end
      PH_DATA: begin
        emit_one      = 1'b1;
        data_left_nxt = data_left_r - 1'b1;
        if (data_left_r == 2'd1) begin
          phase_nxt = PH_DELTA;
        end
      end
      PH_MTYPE: begin
        emit_one     = 1'b1;
        meta_end_nxt = (track_byte == META_END);
        phase_nxt    = PH_MLEN;
      end
      PH_MLEN: begin
        emit_one      = 1'b1;
        meta_left_nxt = track_byte;
        if (track_byte == '0) begin
          phase_nxt = meta_end_r ? PH_DONE : PH_DELTA;
        end else begin
          phase_nxt = PH_MBODY;
        end
      end
      PH_MBODY: begin
        emit_one      = 1'b1;
        meta_left_nxt = meta_left_r - 1'b1;
        if (meta_left_r == 8'd1) begin
          phase_nxt = meta_end_r ? PH_DONE : PH_DELTA;
        end
      end
      default: begin
        phase_nxt = e_phase;
      end
    endcase
    // final source byte closes the track unless it is in error
    phase_fin = (last_in_track && phase_nxt != PH_ERROR) ? PH_DONE : phase_nxt;
  end

  // Job build: delta groups go out most significant first
  always_comb begin
    logic [DC_W-1:0] idx;
    logic [6:0]      gv;
    idx       = '0;
    gv        = '0;
    job_bytes = '0;
    if (emit_delta) begin
      for (int k = 0; k < MAX_DELTA_BYTES; k++) begin
        idx = e_dc - DC_W'(k);
        gv  = (k == 0) ? track_byte[6:0] : groups_r[idx];
        job_bytes[k] = {(idx != '0), gv};
      end
    end else if (emit_one) begin
      job_bytes[0] = track_byte;
    end
    job_cnt                = emit_delta ? CNT_W'(e_dc) + 1'b1 : CNT_W'(1);
    job_flags.clr          = track_start;
    job_flags.has          = emit_delta | emit_one;
    job_flags.track_end    = (phase_fin == PH_DONE) || last_in_track;
    job_flags.format_error = (phase_fin == PH_ERROR);
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DELTA;
      dc_r        <= '0;
      prev_r      <= '0;
      data_left_r <= '0;
      meta_left_r <= '0;
      meta_end_r  <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_fin;
      dc_r        <= dc_nxt;
      prev_r      <= prev_nxt;
      data_left_r <= data_left_nxt;
      meta_left_r <= meta_left_nxt;
      meta_end_r  <= meta_end_nxt;
    end
  end

  // Buffered delta groups
  always_ff @(posedge clk) begin
    if (accept && grp_we) begin
      groups_r[e_dc] <= track_byte[6:0];
    end
  end

endmodule

[design/mtm_back.sv]
// ----------------------------------------------------------------------------
// mtm_back
// Result sequencer: walks each queued job into the output register one result
// per cycle while out_ready allows, and keeps the running byte count.
// ----------------------------------------------------------------------------
module mtm_back import mtm_pkg::*; #(
  parameter int MAX_DELTA_BYTES = MAX_DELTA_BYTES_DEF,
  localparam int KI_W  = (MAX_DELTA_BYTES > 1) ? $clog2(MAX_DELTA_BYTES) : 1,
  localparam int CNT_W = $clog2(MAX_DELTA_BYTES + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  logic [MAX_DELTA_BYTES-1:0][7:0] q_bytes,
  input  logic [CNT_W-1:0]                q_cnt,
  input  job_flags_t                      q_flags,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_data_byte,
  output logic                            out_has_byte,
  output logic                            out_last_of_run,
  output logic                            out_track_end,
  output logic                            out_format_error,
  output logic [31:0]                     out_byte_count
);

  logic [KI_W-1:0] k_r, k_nxt;
  logic [31:0]     count_r, count_nxt, count_base;
  logic            valid_r, valid_nxt;
  logic            load;
  logic            last;
  logic [7:0]      byte_r;
  logic            has_r, last_r, end_r, err_r;

  assign load  = q_valid && (!valid_r || out_ready);
  assign last  = (CNT_W'(k_r) + 1'b1 == q_cnt);
  assign q_pop = load && last;

  // Next result of the head job
  always_comb begin
    count_base = (q_flags.clr && k_r == '0) ? '0 : count_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    valid_nxt  = valid_r && !out_ready;
    if (load) begin
      count_nxt = count_base + 32'(q_flags.has);
      k_nxt     = last ? '0 : k_r + 1'b1;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      k_r     <= k_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= q_bytes[k_r];
      has_r  <= q_flags.has;
      last_r <= last;
      end_r  <= last && q_flags.track_end;
      err_r  <= last && q_flags.format_error;
    end
  end

  assign out_valid        = valid_r;
  assign out_data_byte    = byte_r;
  assign out_has_byte     = has_r;
  assign out_last_of_run  = last_r;
  assign out_track_end    = end_r;
  assign out_format_error = err_r;
  assign out_byte_count   = count_r;

endmodule

[design/mtm_checker.sv]
// ----------------------------------------------------------------------------
// mtm_checker
// Port-level checks on the transcoder's result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_data_byte,
  input logic        out_has_byte,
  input logic        out_last_of_run,
  input logic        out_track_end,
  input logic        out_format_error,
  input logic [31:0] out_byte_count
);

  // Stalled result stays presented
  `MTM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  // Stalled result keeps its payload
  `MTM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data_byte) && $stable(out_byte_count), "payload changed while stalled")
  // Empty result is a lone result with a zero byte
  `MTM_ASSERT_SAME(a_empty_res, out_valid && !out_has_byte, out_last_of_run && out_data_byte == 8'h00, "empty result malformed")
  // Track flags only on the last result of a source byte
  `MTM_ASSERT_SAME(a_flags_last, out_valid && (out_track_end || out_format_error), out_last_of_run, "track flag before last result")

endmodule

bind music_track_to_midi_transcoder_unit mtm_checker u_mtm_checker (.*);

[bench/music_track_to_midi_transcoder_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// music_track_to_midi_transcoder_unit_tb
// Self-checking bench for the track to MIDI transcoder. Source bytes are sent
// as whole tracks: hand-written event streams first, then random well-formed
// tracks with some noise mixed in. A behavioural copy of the transcoder inside
// the bench works out the MIDI results of every accepted byte, and each result
// transaction is checked field by field against them, in order.
// ----------------------------------------------------------------------------
module music_track_to_midi_transcoder_unit_tb;
  import mtm_pkg::*;

  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last_of_run;
    logic        track_end;
    logic        format_error;
    logic [31:0] byte_count;
  } midi_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_track_byte;
  logic        in_track_start;
  logic        in_last_in_track;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_data_byte;
  logic        out_has_byte;
  logic        out_last_of_run;
  logic        out_track_end;
  logic        out_format_error;
  logic [31:0] out_byte_count;

  music_track_to_midi_transcoder_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_track_byte    (in_track_byte),
    .in_track_start   (in_track_start),
    .in_last_in_track (in_last_in_track),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_byte    (out_data_byte),
    .out_has_byte     (out_has_byte),
    .out_last_of_run  (out_last_of_run),
    .out_track_end    (out_track_end),
    .out_format_error (out_format_error),
    .out_byte_count   (out_byte_count)
  );

  // Transcoder state as the bench sees it
  phase_t      trk_phase;
  logic [6:0]  grp_buf [MAX_DELTA_BYTES_DEF];
  int          grp_cnt;
  logic [7:0]  run_status;
  logic [1:0]  data_left;
  logic [8:0]  meta_left;
  logic        meta_is_end;
  logic [31:0] byte_total;

  midi_result_t step_results[$];
  midi_result_t midi_expected[$];
  logic [7:0]   script[$];

  int fail_count;
  int items_sent;
  int live_items;
  int results_checked;
  int bytes_checked;
  int tracks_started;
  int tracks_ended;
  int tracks_failed;
  int idle_cycles;

  bit in_gaps;
  bit out_stalls;
  bit hold_req;
  bit new_track;
  bit noise_on;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Behavioural transcoder
  // ---------------------------------------------------------------------------
  function automatic void clear_track();
    trk_phase   = PH_DELTA;
    foreach (grp_buf[k]) grp_buf[k] = '0;
    grp_cnt     = 0;
    run_status  = '0;
    data_left   = '0;
    meta_left   = '0;
    meta_is_end = 1'b0;
    byte_total  = '0;
  endfunction

  function automatic void put_byte(input logic [7:0] b, input bit has);
    midi_result_t r;
    if (has) byte_total = byte_total + 32'd1;
    r.data_byte    = has ? b : 8'h00;
    r.has_byte     = has;
    r.last_of_run  = 1'b0;
    r.track_end    = 1'b0;
    r.format_error = 1'b0;
    r.byte_count   = byte_total;
    step_results.push_back(r);
  endfunction

  function automatic void close_meta();
    trk_phase = meta_is_end ? PH_DONE : PH_DELTA;
  endfunction

  function automatic void transcode_byte(input logic [7:0] b, input logic s, input logic l);
    logic [7:0]   v;
    int           i;
    midi_result_t r;
    step_results.delete();
    if (s) clear_track();

    case (trk_phase)
      PH_DELTA: begin
        if (b[7]) begin
          // most significant group first, continuation bit on all but the last
          for (i = grp_cnt; i >= 0; i--) begin
            v = (i == grp_cnt) ? (b & GROUP_MASK) : {1'b0, grp_buf[i]};
            if (i != 0) v = v | CONT_BIT;
            put_byte(v, 1'b1);
          end
          grp_cnt   = 0;
          trk_phase = PH_STATUS;
        end else if (grp_cnt + 1 >= MAX_DELTA_BYTES_DEF) begin
          trk_phase = PH_ERROR;
        end else begin
          grp_buf[grp_cnt] = b[6:0];
          grp_cnt++;
        end
      end
      PH_STATUS: begin
        if (b == STATUS_META) begin
          put_byte(b, 1'b1);
          trk_phase = PH_MTYPE;
        end else if (!b[7] || b[7:4] == HI_SYSTEM) begin
          trk_phase = PH_ERROR;
        end else begin
          data_left = (b[7:4] == HI_PROG_CHG || b[7:4] == HI_CHAN_PRES) ? 2'd1 : 2'd2;
          // running status: a repeated status is dropped
          if (b != run_status) put_byte(b, 1'b1);
          run_status = b;
          trk_phase  = PH_DATA;
        end
      end
      PH_DATA: begin
        put_byte(b, 1'b1);
        data_left = data_left - 2'd1;
        if (data_left == 2'd0) trk_phase = PH_DELTA;
      end
      PH_MTYPE: begin
        put_byte(b, 1'b1);
        meta_is_end = (b == META_END);
        trk_phase   = PH_MLEN;
      end
      PH_MLEN: begin
        put_byte(b, 1'b1);
        meta_left = {1'b0, b};
        if (meta_left == '0) close_meta();
        else trk_phase = PH_MBODY;
      end
      PH_MBODY: begin
        put_byte(b, 1'b1);
        meta_left = meta_left - 9'd1;
        if (meta_left == '0) close_meta();
      end
      default: ;
    endcase

    if (step_results.size() == 0) put_byte(8'h00, 1'b0);
    if (l && trk_phase != PH_ERROR) trk_phase = PH_DONE;

    // flags ride on the last result of the step only
    r              = step_results.pop_back();
    r.last_of_run  = 1'b1;
    r.track_end    = (trk_phase == PH_DONE) || l;
    r.format_error = (trk_phase == PH_ERROR);
    step_results.push_back(r);
    foreach (step_results[k]) midi_expected.push_back(step_results[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------
  // One source byte; called at a falling edge, returns at one after it is taken
  task automatic send_byte(input logic [7:0] b, input logic s, input logic l);
    bit open_before;
    if (in_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_track_byte    <= b;
    in_track_start   <= s;
    in_last_in_track <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    open_before = s || (trk_phase != PH_DONE && trk_phase != PH_ERROR);
    if (open_before) live_items++;
    if (s) tracks_started++;
    items_sent++;
    transcode_byte(b, s, l);
    if (open_before && trk_phase == PH_DONE) tracks_ended++;
    if (open_before && trk_phase == PH_ERROR) tracks_failed++;
    @(negedge clk);
  endtask

  // Sends script as one track: first byte starts it
  task automatic play_script(input bit last_at_end);
    foreach (script[k])
      send_byte(script[k], k == 0, last_at_end && (k == script.size() - 1));
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (midi_expected.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Random-track byte; marked final on request or, with noise on, at random
  task automatic feed(input logic [7:0] b, input bit force_last);
    bit l;
    l = force_last || (noise_on && $urandom_range(0, 149) == 0);
    send_byte(b, new_track, l);
    new_track = 1'b0;
  endtask

  // One event: delta time, then a channel event, a meta event or a noise status
  task automatic send_random_event();
    logic [7:0] st;
    int         ng;
    int         kind;
    int         len;
    int         i;
    bit         cut;
    ng = ($urandom_range(0, 3) == 0) ? $urandom_range(2, MAX_DELTA_BYTES_DEF) : 1;
    if (noise_on && $urandom_range(0, 29) == 0) ng = MAX_DELTA_BYTES_DEF + 1;
    for (i = 1; i < ng; i++) feed(8'($urandom_range(0, 127)), 1'b0);
    feed(CONT_BIT | 8'($urandom_range(0, 127)), 1'b0);

    kind = $urandom_range(0, 99);
    if (noise_on && kind < 5) begin
      // data byte or system byte where a status belongs
      if ($urandom_range(0, 1)) st = 8'($urandom_range(0, 127));
      else st = 8'($urandom_range(240, 254));
      feed(st, 1'b0);
    end else if (kind < 72) begin
      if (run_status[7] && $urandom_range(0, 1)) st = run_status;
      else st = 8'($urandom_range(128, 239));
      cut = (kind >= 66);
      feed(st, 1'b0);
      if (st[7:4] == HI_PROG_CHG || st[7:4] == HI_CHAN_PRES) begin
        feed(8'($urandom_range(0, 255)), cut);
      end else begin
        feed(8'($urandom_range(0, 255)), 1'b0);
        feed(8'($urandom_range(0, 255)), cut);
      end
    end else begin
      feed(STATUS_META, 1'b0);
      feed((kind < 80) ? META_END : 8'($urandom_range(0, 255)), 1'b0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 5);
      feed(8'(len), 1'b0);
      repeat (len) feed(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Deltas of one and four groups, data extremes, running status across a meta,
  // zero-length meta, end meta with a body, a byte after the end
  task automatic test_event_stream();
    script = '{8'h80, 8'hEF, 8'h00, 8'hFF,
               8'h7F, 8'h00, 8'h2A, 8'hFF,
               8'hFF, 8'h7F, 8'h00,
               8'h80, 8'hEF, 8'h7F, 8'h80,
               8'h80, 8'hFF, 8'h2F, 8'h01, 8'h55,
               8'hC3};
    play_script(1'b0);
  endtask

  // Fourth group without the last mark, then bytes ignored in error
  task automatic test_overlong_delta();
    script = '{8'h00, 8'h7F, 8'h00, 8'h00, 8'hFF};
    play_script(1'b1);
  endtask

  // Status without bit 7, and a system status
  task automatic test_bad_status();
    script = '{8'h80, 8'h40};
    play_script(1'b0);
    script = '{8'h80, 8'hF7};
    play_script(1'b0);
  endtask

  // Track ends on the final byte: after a delta, mid-event, with a group buffered
  task automatic test_final_input();
    script = '{8'h05, 8'h85};
    play_script(1'b1);
    script = '{8'h80, 8'hC0};
    play_script(1'b1);
    script = '{8'h7F};
    play_script(1'b1);
  endtask

  // Sink holds off while the source keeps offering, then the source waits
  task automatic test_backpressure();
    bit gaps_saved;
    gaps_saved = in_gaps;
    in_gaps    = 1'b0;
    noise_on   = 1'b0;
    new_track  = 1'b1;
    hold_req   = 1'b1;
    repeat (10) send_random_event();
    pause_until_drained();
    in_gaps = gaps_saved;
  endtask

  task automatic test_random_tracks(input int goal, input bit noisy);
    noise_on  = noisy;
    new_track = 1'b1;
    goal      = goal + live_items;
    while (live_items < goal) begin
      send_random_event();
      if (trk_phase == PH_DONE || trk_phase == PH_ERROR) begin
        repeat ($urandom_range(0, 2)) feed(8'($urandom_range(0, 255)), 1'b0);
        new_track = 1'b1;
      end else if (noisy && $urandom_range(0, 39) == 0) begin
        new_track = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (out_stalls && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    midi_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (midi_expected.size() == 0) begin
        $error("result transaction with nothing expected, data_byte %0h", out_data_byte);
        fail_count++;
      end else begin
        want = midi_expected.pop_front();
        check_field("data_byte", 32'(want.data_byte), 32'(out_data_byte));
        check_field("has_byte", 32'(want.has_byte), 32'(out_has_byte));
        check_field("last_of_run", 32'(want.last_of_run), 32'(out_last_of_run));
        check_field("track_end", 32'(want.track_end), 32'(out_track_end));
        check_field("format_error", 32'(want.format_error), 32'(out_format_error));
        check_field("byte_count", want.byte_count, out_byte_count);
        results_checked++;
        if (want.has_byte) bytes_checked++;
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_track_byte    = '0;
    in_track_start   = 1'b0;
    in_last_in_track = 1'b0;
    in_gaps          = 1'b0;
    out_stalls       = 1'b0;
    hold_req         = 1'b0;
    new_track        = 1'b0;
    noise_on         = 1'b0;
    fail_count       = 0;
    items_sent       = 0;
    live_items       = 0;
    results_checked  = 0;
    bytes_checked    = 0;
    tracks_started   = 0;
    tracks_ended     = 0;
    tracks_failed    = 0;
    idle_cycles      = 0;
    clear_track();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_gaps    = 1'b1;
    out_stalls = 1'b1;
    test_event_stream();
    test_overlong_delta();
    test_bad_status();
    test_final_input();
    test_backpressure();
    test_random_tracks(190, 1'b1);

    // closing stretch at full rate on both sides
    in_gaps    = 1'b0;
    out_stalls = 1'b0;
    test_random_tracks(50, 1'b0);
    in_valid <= 1'b0;

    while (midi_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d source bytes over %0d tracks (%0d ended, %0d in error).",
             items_sent, tracks_started, tracks_ended, tracks_failed);
    $display("Checked %0d result transactions, %0d of them carrying MIDI bytes.",
             results_checked, bytes_checked);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[music_track_to_midi_transcoder_unit.f]
+incdir+design
design/mtm_pkg.sv
design/mtm_queue.sv
design/mtm_front.sv
design/mtm_back.sv
design/music_track_to_midi_transcoder_unit.sv
design/mtm_checker.sv
bench/music_track_to_midi_transcoder_unit_tb.sv
